// File: rtl/sps_pkg.sv
// Package for the stepper phase sequencer: item types, constants and coil tables.
package sps_pkg;

	localparam int unsigned ANGLE_W  = 13;
	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned CYCLE_W  = 13;
	localparam int unsigned COIL_W   = 4;
	localparam int unsigned PHASE_W  = 3;

	// floor(angle*64/45) as (angle * ceil(2^25/45)) >> 19, exact for every 13-bit angle
	localparam logic [19:0] CYC_RECIP = 20'd745655;
	localparam int unsigned CYC_SHIFT = 19;
	localparam int unsigned CYC_PROD_W = ANGLE_W + 20;
	localparam int unsigned CYC_RAW_W  = CYC_PROD_W - CYC_SHIFT;
	localparam logic [CYCLE_W-1:0] MAX_CYCLES = 13'd8191;

	localparam logic [PHASE_W-1:0] FULL_LAST = 3'd3;
	localparam logic [PHASE_W-1:0] HALF_LAST = 3'd7;

	// Command codes
	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_START = 1'b1
	} cmd_code_t;

	// Accepted command after the cycle count has been worked out
	typedef struct packed {
		cmd_code_t          cmd;
		logic [CYCLE_W-1:0] cycles;
		logic               dir_ccw;
		logic               half_step;
		logic [HOLD_W-1:0]  hold_ticks;
	} cmd_item_t;

	// One result transaction
	typedef struct packed {
		logic [COIL_W-1:0] coils;
		logic              busy_res;
		logic              move_done;
		logic              rejected;
	} res_item_t;

	// Coil pattern for a position in the cycle
	function automatic logic [COIL_W-1:0] pattern_at(
		input logic               half,
		input logic               ccw,
		input logic [PHASE_W-1:0] idx
	);
		logic [PHASE_W-1:0] i;
		logic [COIL_W-1:0]  pat;
		begin
			pat = '0;
			if (half) begin
				i = ccw ? (HALF_LAST - idx) : idx;
				case (i)
					3'd0:    pat = 4'h9;
					3'd1:    pat = 4'h1;
					3'd2:    pat = 4'h3;
					3'd3:    pat = 4'h2;
					3'd4:    pat = 4'h6;
					3'd5:    pat = 4'h4;
					3'd6:    pat = 4'hC;
					default: pat = 4'h8;
				endcase
			end else begin
				i = ccw ? (FULL_LAST - {1'b0, idx[1:0]}) : {1'b0, idx[1:0]};
				case (i[1:0])
					2'd0:    pat = 4'h1;
					2'd1:    pat = 4'h2;
					2'd2:    pat = 4'h4;
					default: pat = 4'h8;
				endcase
			end
			return pat;
		end
	endfunction

endpackage

// File: rtl/sps_cmd_if.sv
// Command channel: valid/ready handshake with the move command payload.
interface sps_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [sps_pkg::ANGLE_W-1:0]   angle_deg;
	logic                          dir_ccw;
	logic                          half_step;
	logic [sps_pkg::HOLD_W-1:0]    hold_ticks;

	modport source (output valid, cmd, angle_deg, dir_ccw, half_step, hold_ticks,
		input ready);
	modport sink (input valid, cmd, angle_deg, dir_ccw, half_step, hold_ticks,
		output ready);
endinterface

// File: rtl/sps_res_if.sv
// Result channel: valid/ready handshake with the coil and status payload.
interface sps_res_if;
	logic                         valid;
	logic                         ready;
	logic [sps_pkg::COIL_W-1:0]   coils;
	logic                         busy_res;
	logic                         move_done;
	logic                         rejected;

	modport source (output valid, coils, busy_res, move_done, rejected, input ready);
	modport sink (input valid, coils, busy_res, move_done, rejected, output ready);
endinterface

// File: rtl/sps_cycle_calc.sv
// Cycle count of a move: floor(angle*64/45) by reciprocal multiply, saturated.
module sps_cycle_calc (
	input  logic [sps_pkg::ANGLE_W-1:0] angle_deg,
	output logic [sps_pkg::CYCLE_W-1:0] cycles
);

	logic [sps_pkg::CYC_PROD_W-1:0] prod;
	logic [sps_pkg::CYC_RAW_W-1:0]  raw;

	// Multiply by the scaled reciprocal of 45 and drop the fraction
	assign prod = sps_pkg::CYC_PROD_W'(angle_deg) * sps_pkg::CYC_PROD_W'(sps_pkg::CYC_RECIP);
	assign raw  = prod[sps_pkg::CYC_PROD_W-1:sps_pkg::CYC_SHIFT];

	// Clamp to the largest count the counter holds
	always_comb begin
		if (raw > sps_pkg::CYC_RAW_W'(sps_pkg::MAX_CYCLES)) begin
			cycles = sps_pkg::MAX_CYCLES;
		end else begin
			cycles = raw[sps_pkg::CYCLE_W-1:0];
		end
	end

endmodule

// File: rtl/sps_move_ctrl.sv
// Move state: phase position, hold countdown and cycle count; one update per transaction.
module sps_move_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  sps_pkg::cmd_item_t  item,
	output sps_pkg::res_item_t  res
);

	logic [sps_pkg::COIL_W-1:0]  coil_q, coil_d;
	logic [sps_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [sps_pkg::CYCLE_W-1:0] left_q, left_d;
	logic [sps_pkg::HOLD_W-1:0]  hcnt_q, hcnt_d;
	logic [sps_pkg::HOLD_W-1:0]  hlat_q, hlat_d;
	logic                        dir_q, dir_d;
	logic                        mode_q, mode_d;
	logic                        busy_q, busy_d;
	logic                        done, rej;
	logic [sps_pkg::PHASE_W-1:0] last_idx;
	logic [sps_pkg::PHASE_W-1:0] next_idx;
	logic [sps_pkg::CYCLE_W-1:0] left_dec;
	logic                        wrap;

	assign last_idx = mode_q ? sps_pkg::HALF_LAST : sps_pkg::FULL_LAST;
	assign wrap     = (phase_q == last_idx);
	assign next_idx = wrap ? '0 : phase_q + 1'b1;
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	// Next state for the current transaction
	always_comb begin
		coil_d  = coil_q;
		phase_d = phase_q;
		left_d  = left_q;
		hcnt_d  = hcnt_q;
		hlat_d  = hlat_q;
		dir_d   = dir_q;
		mode_d  = mode_q;
		busy_d  = busy_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (item.cmd == sps_pkg::CMD_START) begin
			if (busy_q) begin
				rej = 1'b1;
			end else if (item.cycles == '0) begin
				done = 1'b1;
			end else begin
				// latch the move and drive the first pattern
				dir_d   = item.dir_ccw;
				mode_d  = item.half_step;
				hlat_d  = (item.hold_ticks == '0) ? sps_pkg::HOLD_W'(1) : item.hold_ticks;
				hcnt_d  = hlat_d;
				left_d  = item.cycles;
				phase_d = '0;
				coil_d  = sps_pkg::pattern_at(item.half_step, item.dir_ccw, '0);
				busy_d  = 1'b1;
			end
		end else if (busy_q) begin
			if (hcnt_q > sps_pkg::HOLD_W'(1)) begin
				hcnt_d = hcnt_q - 1'b1;
			end else begin
				if (wrap) begin
					left_d = left_dec;
				end
				if (wrap && left_dec == '0) begin
					// last hold over: keep the pattern, go idle
					hcnt_d  = '0;
					phase_d = '0;
					busy_d  = 1'b0;
					done    = 1'b1;
				end else begin
					phase_d = next_idx;
					hcnt_d  = hlat_q;
					coil_d  = sps_pkg::pattern_at(mode_q, dir_q, next_idx);
				end
			end
		end
	end

	// Result shows the state after the update
	assign res.coils     = coil_d;
	assign res.busy_res  = busy_d;
	assign res.move_done = done;
	assign res.rejected  = rej;

	// Commit the update when the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q  <= '0;
			phase_q <= '0;
			left_q  <= '0;
			hcnt_q  <= '0;
			hlat_q  <= '0;
			dir_q   <= 1'b0;
			mode_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else if (en) begin
			coil_q  <= coil_d;
			phase_q <= phase_d;
			left_q  <= left_d;
			hcnt_q  <= hcnt_d;
			hlat_q  <= hlat_d;
			dir_q   <= dir_d;
			mode_q  <= mode_d;
			busy_q  <= busy_d;
		end
	end

endmodule

// File: rtl/stepper_phase_sequencer.sv
// Unipolar stepper sequencer: full step and half step coil phases from tick and move commands.
// Pipeline: a result passes through the input register and the result register, with the
// move state updated as the item leaves the input register.
// Throughput: one transaction per cycle; the only limit is the result side's ready.
// Reset (arst_n low): coils off, idle, both pipeline stages empty.
module stepper_phase_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	sps_cmd_if.sink    cmd_ch,
	sps_res_if.source  res_ch
);

	sps_pkg::cmd_item_t          item_s1;
	sps_pkg::res_item_t          res_s2;
	sps_pkg::res_item_t          res_next;
	logic                        vld_s1, vld_s2;
	logic                        adv;
	logic                        take;
	logic [sps_pkg::CYCLE_W-1:0] cycles;

	assign adv          = !vld_s2 || res_ch.ready;
	assign cmd_ch.ready = !vld_s1 || adv;
	assign take         = cmd_ch.valid && cmd_ch.ready;

	sps_cycle_calc u_cycle_calc (
		.angle_deg (cmd_ch.angle_deg),
		.cycles    (cycles)
	);

	sps_move_ctrl u_move_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && vld_s1),
		.item   (item_s1),
		.res    (res_next)
	);

	// Track occupancy of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Capture the command and its cycle count
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd        <= sps_pkg::cmd_code_t'(cmd_ch.cmd);
			item_s1.cycles     <= cycles;
			item_s1.dir_ccw    <= cmd_ch.dir_ccw;
			item_s1.half_step  <= cmd_ch.half_step;
			item_s1.hold_ticks <= cmd_ch.hold_ticks;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_s2 <= res_next;
		end
	end

	assign res_ch.valid     = vld_s2;
	assign res_ch.coils     = res_s2.coils;
	assign res_ch.busy_res  = res_s2.busy_res;
	assign res_ch.move_done = res_s2.move_done;
	assign res_ch.rejected  = res_s2.rejected;

endmodule

// File: tb/stepper_phase_sequencer_tb.sv
// Testbench for the stepper phase sequencer: directed table, random moves, self-checking predictor.
`timescale 1ns / 100ps

module stepper_phase_sequencer_tb;

	localparam int unsigned CYCLE_CAP = 8191;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned LONG_STALL = 250;
	localparam int unsigned DRAIN_CYCLES = 8;

	localparam sps_pkg::cmd_code_t TICK  = sps_pkg::CMD_TICK;
	localparam sps_pkg::cmd_code_t START = sps_pkg::CMD_START;

	// One command transaction as driven on the command channel
	typedef struct packed {
		sps_pkg::cmd_code_t          cmd;
		logic [sps_pkg::ANGLE_W-1:0] angle;
		logic                        ccw;
		logic                        half;
		logic [sps_pkg::HOLD_W-1:0]  hold;
	} move_req_t;

	// Directed row: command, whether the result is typed in, and that result
	typedef struct packed {
		move_req_t          req;
		logic               typed;
		sps_pkg::res_item_t want;
	} step_row_t;

	// Sequencer state as tracked by the predictor
	typedef struct {
		logic [sps_pkg::COIL_W-1:0]  coils;
		logic [sps_pkg::PHASE_W-1:0] idx;
		logic [sps_pkg::CYCLE_W-1:0] cycles_left;
		logic [sps_pkg::HOLD_W-1:0]  hold_cnt;
		logic [sps_pkg::HOLD_W-1:0]  hold_set;
		logic                        ccw;
		logic                        half;
		logic                        busy;
	} seq_state_t;

	localparam logic [3:0] ONE_COIL [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
	localparam logic [3:0] TWO_COIL [8] = '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8};

	// Directed steps: extremes, zero-length move, rejection, full step clockwise and half step both ways
	localparam int unsigned N_DIRECTED = 25;
	localparam step_row_t DIRECTED [N_DIRECTED] = '{
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b1, '{4'h0, 1'b0, 1'b0, 1'b0}},
		'{'{START, 13'd0,    1'b1, 1'b1, 8'd255}, 1'b1, '{4'h0, 1'b0, 1'b1, 1'b0}},
		'{'{START, 13'd1,    1'b0, 1'b0, 8'd0},   1'b1, '{4'h1, 1'b1, 1'b0, 1'b0}},
		'{'{START, 13'd8191, 1'b1, 1'b1, 8'd255}, 1'b1, '{4'h1, 1'b1, 1'b0, 1'b1}},
		'{'{TICK,  13'd8191, 1'b1, 1'b1, 8'd255}, 1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{START, 13'd1,    1'b1, 1'b1, 8'd0},   1'b1, '{4'h8, 1'b1, 1'b0, 1'b0}},
		'{'{START, 13'd5759, 1'b0, 1'b0, 8'd1},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{START, 13'd1,    1'b0, 1'b1, 8'd2},   1'b1, '{4'h9, 1'b1, 1'b0, 1'b0}},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0},
		'{'{TICK,  13'd0,    1'b0, 1'b0, 8'd0},   1'b0, '0}
	};

	logic clk;
	logic arst_n;

	sps_cmd_if cmd_ch();
	sps_res_if res_ch();

	stepper_phase_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	seq_state_t                 seq;
	sps_pkg::res_item_t         expected_coils [$];
	int unsigned errors;
	int unsigned n_items;
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned moves_done;
	int unsigned zero_moves;
	int unsigned rejects;
	bit          no_idle;
	bit          hold_off_req;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Coil pattern at a position of the latched cycle
	function automatic logic [sps_pkg::COIL_W-1:0] coil_at(
		input logic [sps_pkg::PHASE_W-1:0] idx
	);
		logic [sps_pkg::PHASE_W-1:0] i;
		logic [1:0]                  j;
		if (seq.half) begin
			i = seq.ccw ? (3'd7 - idx) : idx;
			return TWO_COIL[i];
		end
		j = seq.ccw ? (2'd3 - idx[1:0]) : idx[1:0];
		return ONE_COIL[j];
	endfunction

	// Advance the sequencer state by one transaction and return the expected result
	function automatic sps_pkg::res_item_t seq_advance(input move_req_t m);
		sps_pkg::res_item_t r;
		int unsigned        cyc;
		int unsigned        nxt;
		bit                 wrapped;
		r = '0;
		if (m.cmd == sps_pkg::CMD_START) begin
			if (seq.busy) begin
				r.rejected = 1'b1;
				rejects++;
			end else begin
				cyc = (32'(m.angle) * 64) / 45;
				if (cyc > CYCLE_CAP)
					cyc = CYCLE_CAP;
				if (cyc == 0) begin
					r.move_done = 1'b1;
					zero_moves++;
				end else begin
					seq.ccw         = m.ccw;
					seq.half        = m.half;
					seq.hold_set    = (m.hold == '0) ? 8'd1 : m.hold;
					seq.cycles_left = sps_pkg::CYCLE_W'(cyc);
					seq.idx         = '0;
					seq.hold_cnt    = seq.hold_set;
					seq.coils       = coil_at(3'd0);
					seq.busy        = 1'b1;
				end
			end
		end else if (seq.busy) begin
			if (seq.hold_cnt > 8'd1) begin
				seq.hold_cnt = seq.hold_cnt - 8'd1;
			end else begin
				nxt = int'(seq.idx) + 1;
				wrapped = 1'b0;
				if (nxt >= (seq.half ? 8 : 4)) begin
					nxt = 0;
					wrapped = 1'b1;
					if (seq.cycles_left != '0)
						seq.cycles_left = seq.cycles_left - 1'b1;
				end
				if (wrapped && seq.cycles_left == '0) begin
					seq.hold_cnt = '0;
					seq.idx      = '0;
					seq.busy     = 1'b0;
					r.move_done  = 1'b1;
					moves_done++;
				end else begin
					seq.idx      = sps_pkg::PHASE_W'(nxt);
					seq.hold_cnt = seq.hold_set;
					seq.coils    = coil_at(sps_pkg::PHASE_W'(nxt));
				end
			end
		end
		r.coils    = seq.coils;
		r.busy_res = seq.busy;
		return r;
	endfunction

	// Offer one transaction, wait for acceptance, record its expected result
	task automatic put_item(input move_req_t m, input bit typed,
		input sps_pkg::res_item_t want);
		sps_pkg::res_item_t r;
		int unsigned        gap;
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.cmd        <= m.cmd;
		cmd_ch.angle_deg  <= m.angle;
		cmd_ch.dir_ccw    <= m.ccw;
		cmd_ch.half_step  <= m.half;
		cmd_ch.hold_ticks <= m.hold;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (m.cmd == sps_pkg::CMD_START || seq.busy)
			n_items++;
		n_sent++;
		r = seq_advance(m);
		expected_coils.push_back(typed ? want : r);
		// insert a random idle burst, except in quiet windows and the final part
		if (!no_idle && ((n_sent / 64) % 4) != 3 && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every expected result has come back
	task automatic wait_drained();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_coils.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random ready, one long hold-off on request, field checks
	initial begin : result_sink
		int unsigned        stall_left;
		int unsigned        cyc;
		sps_pkg::res_item_t want;
		stall_left = 0;
		cyc = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = LONG_STALL;
			end else if (stall_left == 0 && !no_idle && ((cyc / 400) % 4) != 3
					&& $urandom_range(0, 99) < 15) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (expected_coils.size() == 0) begin
					$error("unexpected result: coils %h busy %b done %b rejected %b",
						res_ch.coils, res_ch.busy_res, res_ch.move_done, res_ch.rejected);
					errors++;
				end else begin
					want = expected_coils.pop_front();
					n_checked++;
					if (res_ch.coils !== want.coils) begin
						$error("coils: expected %h, got %h", want.coils, res_ch.coils);
						errors++;
					end
					if (res_ch.busy_res !== want.busy_res) begin
						$error("busy_res: expected %b, got %b", want.busy_res, res_ch.busy_res);
						errors++;
					end
					if (res_ch.move_done !== want.move_done) begin
						$error("move_done: expected %b, got %b", want.move_done,
							res_ch.move_done);
						errors++;
					end
					if (res_ch.rejected !== want.rejected) begin
						$error("rejected: expected %b, got %b", want.rejected, res_ch.rejected);
						errors++;
					end
				end
			end
		end
	end

	// Main stimulus
	initial begin : stimulus
		move_req_t   m;
		move_req_t   last_move;
		int unsigned r;
		int unsigned k;
		bit          stalled;
		bit          paused;
		errors = 0;
		n_items = 0;
		n_sent = 0;
		n_checked = 0;
		moves_done = 0;
		zero_moves = 0;
		rejects = 0;
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		stalled = 1'b0;
		paused = 1'b0;
		seq = '{default: '0};
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = sps_pkg::CMD_TICK;
		cmd_ch.angle_deg = '0;
		cmd_ch.dir_ccw = 1'b0;
		cmd_ch.half_step = 1'b0;
		cmd_ch.hold_ticks = '0;

		// hold reset, then release it away from the rising edge
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		for (int i = 0; i < N_DIRECTED; i++)
			put_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
		wait_drained();

		// random moves with ticks, idle ticks, zero-length moves and rejected starts
		while (n_items < RANDOM_ITEMS) begin
			if (n_items >= 300 && !stalled) begin
				stalled = 1'b1;
				hold_off_req = 1'b1;
			end
			if (n_items >= 600 && !paused) begin
				paused = 1'b1;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			m.cmd   = sps_pkg::CMD_TICK;
			m.angle = sps_pkg::ANGLE_W'($urandom_range(0, 8191));
			m.ccw   = 1'($urandom_range(0, 1));
			m.half  = 1'($urandom_range(0, 1));
			m.hold  = sps_pkg::HOLD_W'($urandom_range(0, 255));
			if (!seq.busy) begin
				if (r >= 8)
					m.cmd = sps_pkg::CMD_START;
				if (r >= 8 && r < 14) begin
					m.angle = '0;
				end else if (r >= 14) begin
					k = $urandom_range(0, 99);
					if (k < 2) begin
						m.angle = 13'd1;
						m.half  = 1'b0;
						m.hold  = sps_pkg::HOLD_W'($urandom_range(16, 255));
					end else if (k < 7) begin
						m.angle = sps_pkg::ANGLE_W'($urandom_range(13, 90));
						m.hold  = sps_pkg::HOLD_W'($urandom_range(0, 1));
					end else begin
						m.angle = sps_pkg::ANGLE_W'($urandom_range(1, 12));
						m.hold  = (k < 80) ? sps_pkg::HOLD_W'($urandom_range(0, 3))
							: sps_pkg::HOLD_W'($urandom_range(4, 15));
					end
				end
			end else if (r >= 90) begin
				m.cmd = sps_pkg::CMD_START;
			end
			put_item(m, 1'b0, '0);
		end

		// final part without idling: finish the move, then a short half-step move
		no_idle = 1'b1;
		m = '{sps_pkg::CMD_TICK, 13'd0, 1'b0, 1'b0, 8'd0};
		while (seq.busy)
			put_item(m, 1'b0, '0);
		last_move = '{sps_pkg::CMD_START, 13'd3, 1'b1, 1'b1, 8'd1};
		put_item(last_move, 1'b0, '0);
		while (seq.busy)
			put_item(m, 1'b0, '0);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// drain and let the pipeline settle
		while (expected_coils.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results over %0d transactions: %0d moves, %0d zero-length",
			n_checked, n_sent, moves_done, zero_moves);
		$display("Full and half step both ways, holds 0 to 255, %0d starts rejected while busy",
			rejects);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: stepper_phase_sequencer.f
rtl/sps_pkg.sv
rtl/sps_cmd_if.sv
rtl/sps_res_if.sv
rtl/sps_cycle_calc.sv
rtl/sps_move_ctrl.sv
rtl/stepper_phase_sequencer.sv
tb/stepper_phase_sequencer_tb.sv
